FILE: hw/rtl/aps_pkg.sv
package aps_pkg;

	localparam int KindW     = 3;
	localparam int DurW      = 15;
	localparam int RegIdxW   = 2;
	localparam int RegDataW  = 1;
	localparam int PhaseW    = 4;
	localparam int BlinkW    = 10;
	localparam int PatternW  = 12;
	localparam int MsW       = 10;

	localparam logic [KindW-1:0] KIND_TICK   = 3'd0;
	localparam logic [KindW-1:0] KIND_PROMPT = 3'd1;
	localparam logic [KindW-1:0] KIND_BEEP   = 3'd2;
	localparam logic [KindW-1:0] KIND_SHAKE  = 3'd3;
	localparam logic [KindW-1:0] KIND_LIGHT  = 3'd4;

	localparam logic [RegIdxW-1:0] REG_BEEP_EN  = 2'd0;
	localparam logic [RegIdxW-1:0] REG_SHAKE_EN = 2'd1;
	localparam logic [RegIdxW-1:0] REG_LIGHT_EN = 2'd2;

	localparam logic [PhaseW-1:0]   PHASE_MAX   = 4'd8;
	localparam logic [BlinkW-1:0]   BLINK_MAX   = 10'd800;
	localparam logic [PatternW-1:0] PAT_FIRST   = 12'd200;
	localparam logic [PatternW-1:0] PAT_SECOND  = 12'd600;
	localparam logic [PatternW-1:0] PAT_THIRD   = 12'd1000;
	localparam logic [PatternW-1:0] PAT_END     = 12'd2000;
	localparam logic [MsW-1:0]      MS_MAX      = 10'd1000;
	localparam logic [DurW-1:0]     BEEP_MS     = 15'd200;
	localparam logic [DurW-1:0]     SHAKE_MS    = 15'd300;
	localparam logic [DurW-1:0]     LIGHT_MS    = 15'd2500;

	typedef struct packed {
		logic light;
		logic shake;
		logic beep;
	} cfg_t;

	typedef struct packed {
		logic             busy;
		logic [DurW-1:0]  duration;
		logic [KindW-1:0] kind;
	} item_t;

	typedef struct packed {
		logic [PhaseW-1:0] decode_phase;
		logic              prompt_running;
		logic              led_lit;
		logic              motor_on;
		logic              buzzer_on;
	} res_t;

endpackage

FILE: hw/rtl/aps_core.sv
module aps_core
	import aps_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  fire,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  res
);

	logic                beep_act_q, beep_act_d;
	logic [DurW-1:0]     beep_left_q, beep_left_d;
	logic                shake_act_q, shake_act_d;
	logic [DurW-1:0]     shake_left_q, shake_left_d;
	logic                light_act_q, light_act_d;
	logic [DurW-1:0]     light_left_q, light_left_d;
	logic [BlinkW-1:0]   blink_q, blink_d;
	logic                led_q, led_d;
	logic                prompt_q, prompt_d;
	logic [PatternW-1:0] pattern_q, pattern_d, pattern_inc;
	logic [MsW-1:0]      ms_q, ms_d, ms_base, ms_inc;
	logic [DurW-1:0]     sec_q, sec_d;
	logic [PhaseW-1:0]   phase_q, phase_d;

	always_comb begin
		beep_act_d   = beep_act_q;
		beep_left_d  = beep_left_q;
		shake_act_d  = shake_act_q;
		shake_left_d = shake_left_q;
		light_act_d  = light_act_q;
		light_left_d = light_left_q;
		blink_d      = blink_q;
		led_d        = led_q;
		prompt_d     = prompt_q;
		pattern_d    = pattern_q;
		ms_d         = ms_q;
		sec_d        = sec_q;
		phase_d      = phase_q;
		pattern_inc  = pattern_q + 12'd1;
		ms_base      = ms_q;
		ms_inc       = ms_q + 10'd1;
		if (fire) begin
			case (item.kind)
				KIND_TICK: begin
					if (!item.busy)
						phase_d = (phase_q == PHASE_MAX) ? '0 : phase_q + 4'd1;
					if (beep_act_q) begin
						if (beep_left_q != '0) beep_left_d = beep_left_q - 15'd1;
						if (beep_left_d == '0) beep_act_d = 1'b0;
					end
					if (shake_act_q) begin
						if (shake_left_q != '0) shake_left_d = shake_left_q - 15'd1;
						if (shake_left_d == '0) shake_act_d = 1'b0;
					end
					if (light_act_q) begin
						if (blink_q == BLINK_MAX) begin
							led_d   = !led_q;
							blink_d = '0;
						end else begin
							blink_d = blink_q + 10'd1;
						end
						if (light_left_q == '0) begin
							led_d       = 1'b0;
							light_act_d = 1'b0;
							blink_d     = '0;
						end else begin
							light_left_d = light_left_q - 15'd1;
						end
					end
					if (prompt_q) begin
						pattern_d = pattern_inc;
						if (pattern_inc == PAT_FIRST || pattern_inc == PAT_THIRD) begin
							if (cfg.beep) begin
								beep_left_d = BEEP_MS;
								beep_act_d  = 1'b1;
							end
							if (cfg.shake) begin
								shake_left_d = SHAKE_MS;
								shake_act_d  = 1'b1;
							end
						end else if (pattern_inc == PAT_SECOND) begin
							if (cfg.beep) begin
								beep_left_d = BEEP_MS;
								beep_act_d  = 1'b1;
							end
						end else if (pattern_inc > PAT_END) begin
							pattern_d = '0;
							ms_base   = '0;
							if (cfg.light) begin
								light_left_d = LIGHT_MS;
								light_act_d  = 1'b1;
								led_d        = 1'b1;
							end
						end
						ms_inc = ms_base + 10'd1;
						ms_d   = ms_inc;
						if (ms_inc > MS_MAX) begin
							ms_d = '0;
							if (sec_q != '0) sec_d = sec_q - 15'd1;
							if (sec_d == '0) begin
								prompt_d     = 1'b0;
								beep_left_d  = '0;
								shake_left_d = '0;
								blink_d      = '0;
							end
						end
					end
					if (!beep_act_d && !shake_act_d && !light_act_d) led_d = 1'b0;
				end
				KIND_PROMPT: begin
					prompt_d  = 1'b1;
					sec_d     = item.duration;
					pattern_d = '0;
					ms_d      = '0;
				end
				KIND_BEEP: begin
					beep_left_d = item.duration;
					beep_act_d  = 1'b1;
				end
				KIND_SHAKE: begin
					shake_left_d = item.duration;
					shake_act_d  = 1'b1;
				end
				KIND_LIGHT: begin
					light_left_d = item.duration;
					light_act_d  = 1'b1;
					led_d        = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beep_act_q   <= 1'b0;
			beep_left_q  <= '0;
			shake_act_q  <= 1'b0;
			shake_left_q <= '0;
			light_act_q  <= 1'b0;
			light_left_q <= '0;
			blink_q      <= '0;
			led_q        <= 1'b0;
			prompt_q     <= 1'b0;
			pattern_q    <= '0;
			ms_q         <= '0;
			sec_q        <= '0;
			phase_q      <= '0;
		end else begin
			beep_act_q   <= beep_act_d;
			beep_left_q  <= beep_left_d;
			shake_act_q  <= shake_act_d;
			shake_left_q <= shake_left_d;
			light_act_q  <= light_act_d;
			light_left_q <= light_left_d;
			blink_q      <= blink_d;
			led_q        <= led_d;
			prompt_q     <= prompt_d;
			pattern_q    <= pattern_d;
			ms_q         <= ms_d;
			sec_q        <= sec_d;
			phase_q      <= phase_d;
		end
	end

	assign res.buzzer_on      = beep_act_d;
	assign res.motor_on       = shake_act_d;
	assign res.led_lit        = led_d;
	assign res.prompt_running = prompt_d;
	assign res.decode_phase   = phase_d;

`ifndef SYNTH
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PHASE_MAX) else $error("decode phase out of range");
	a_blink_range: assert property (@(posedge clk) disable iff (!arst_n)
		blink_q <= BLINK_MAX) else $error("blink count out of range");
	a_pattern_range: assert property (@(posedge clk) disable iff (!arst_n)
		pattern_q <= PAT_END && ms_q <= MS_MAX) else $error("pattern counters out of range");
	a_led_needs_light: assert property (@(posedge clk) disable iff (!arst_n)
		led_q |-> light_act_q) else $error("LED lit without light timer");
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(phase_q) && $stable(pattern_q) && $stable(blink_q))
		else $error("state moved without an item");
`endif

endmodule

FILE: hw/rtl/alert_pattern_sequencer.sv
// Channel  Direction  Ports                                Contents
// s_*      in         s_tvalid s_tready s_tdata s_tuser    tick, prompt, beep, shake or light item
// m_*      out        m_tvalid m_tready m_tdata            status after the item
// cfg_*    in         cfg_we cfg_index cfg_wdata           prompt enables
//
// An item is taken into an input register, updated against the sequencer
// state and its status lands in an output register; one item per cycle is
// sustained while m_tready stays high.
// While a status waits, the input register takes one more item, then s_tready drops.
// arst_n clears the core state, the enables and both valid flags; item and status data are not reset.
module alert_pattern_sequencer
	import aps_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [15:0]         s_tdata,   // duration[14:0], decoding_busy[15]
	input  logic [KindW-1:0]    s_tuser,   // kind[2:0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,   // buzzer_on[0], motor_on[1], led_lit[2],
	                                       // prompt_running[3], decode_phase[7:4]
	input  logic                cfg_we,
	input  logic [RegIdxW-1:0]  cfg_index,
	input  logic [RegDataW-1:0] cfg_wdata
);

	logic  valid_s1;
	item_t item_s1;
	logic  out_valid_q;
	res_t  res_q;
	res_t  res;
	cfg_t  cfg_q;
	logic  fire;

	assign fire     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			cfg_q       <= '0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (fire) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_BEEP_EN:  cfg_q.beep  <= cfg_wdata[0];
					REG_SHAKE_EN: cfg_q.shake <= cfg_wdata[0];
					REG_LIGHT_EN: cfg_q.light <= cfg_wdata[0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.kind     <= s_tuser;
			item_s1.duration <= s_tdata[DurW-1:0];
			item_s1.busy     <= s_tdata[DurW];
		end
		if (fire) res_q <= res;
	end

	aps_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = res_q;

endmodule
